/* hdl/pic_pkg.sv */
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the inbreeding coefficient block
// Widths of the individual index, parent codes, Q2.30 values and the
// job / result bundles exchanged between the top level and the walk engine.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int MAX_ANIMALS = 1024;
    localparam int IDX_W       = $clog2(MAX_ANIMALS);
    localparam int CODE_W      = IDX_W + 1;          // parent index plus one, 0 = unknown
    localparam int CNT_W       = $clog2(MAX_ANIMALS + 1);
    localparam int VAL_W       = 32;                 // Q2.30 working width
    localparam int FV_W        = 31;                 // stored F and d width
    localparam int LW_W        = VAL_W + 1;          // listed flag plus path weight
    localparam int PAR_W       = 2 * CODE_W;

    localparam logic [VAL_W-1:0] Q_ONE = 32'h4000_0000;
    localparam logic [VAL_W-1:0] SAT32 = 32'hFFFF_FFFF;

    // One individual handed to the walk engine
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] sire_code;
        logic [CODE_W-1:0] dam_code;
        logic              err;
    } job_t;

    // One finished individual
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [FV_W-1:0]  f;
        logic [FV_W-1:0]  dv;
        logic             err;
        logic             sat;
    } res_t;

endpackage

/* hdl/pic_ram.sv */
// ----------------------------------------------------------------------------
// pic_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pic_walk.sv */
// ----------------------------------------------------------------------------
// pic_walk: ancestor walk engine
// Computes d from the parents' F, then scans the path weight store from the
// individual downward, visiting every listed ancestor, pushing half its
// weight into its parents and accumulating l^2*d. The scan clears what it
// visits, so the store is all zero again when the next item starts.
// ----------------------------------------------------------------------------
module pic_walk (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  pic_pkg::job_t job,
    output logic          idle,
    input  logic          out_free,
    output logic          done,
    output pic_pkg::res_t res
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_F0, ST_F1, ST_P0R, ST_P0W, ST_P1R, ST_P1W,
        ST_SR, ST_SC, ST_FIN
    } state_t;

    state_t                          state_reg;
    logic [pic_pkg::IDX_W-1:0]       idx_reg;
    logic [pic_pkg::IDX_W-1:0]       k_reg;
    logic [pic_pkg::IDX_W-1:0]       clr_reg;
    logic [pic_pkg::CODE_W-1:0]      sc_reg;
    logic [pic_pkg::CODE_W-1:0]      dc_reg;
    logic [pic_pkg::VAL_W-1:0]       cur_l_reg;
    logic [pic_pkg::FV_W-1:0]        cur_dv_reg;
    logic [pic_pkg::FV_W-1:0]        dv_reg;
    logic [pic_pkg::VAL_W-1:0]       sq_reg;
    logic [pic_pkg::VAL_W-1:0]       term_reg;
    logic [pic_pkg::VAL_W-1:0]       sum_reg;
    logic                            err_reg;
    logic                            sat_reg;

    // memory ports
    logic                            l_we;
    logic [pic_pkg::IDX_W-1:0]       l_waddr, l_raddr;
    logic [pic_pkg::LW_W-1:0]        l_wdata, l_rdata;
    logic                            f_we;
    logic [pic_pkg::IDX_W-1:0]       f_raddr;
    logic [pic_pkg::FV_W-1:0]        f_rdata;
    logic                            pd_we;
    logic [pic_pkg::IDX_W-1:0]       pd_raddr;
    logic [pic_pkg::PAR_W-1:0]       par_rdata;
    logic [pic_pkg::FV_W-1:0]        d_rdata;

    // datapath
    logic [pic_pkg::VAL_W-1:0]       quarter;
    logic [pic_pkg::FV_W-1:0]        dv_fin;
    logic [63:0]                     sq_full, term_full;
    logic [pic_pkg::VAL_W:0]         l_add, sum_add;
    logic [pic_pkg::VAL_W-1:0]       f_diff;
    logic [pic_pkg::FV_W-1:0]        f_val;
    logic                            f_clip;

    // parent quarter (1 + F) / 4
    assign quarter = (pic_pkg::Q_ONE + pic_pkg::VAL_W'(f_rdata)) >> 2;
    assign dv_fin  = dv_reg - ((dc_reg != '0) ? quarter[pic_pkg::FV_W-1:0] : '0);

    // squared weight and term, each clipped after the Q2.30 shift
    assign sq_full   = (64'(cur_l_reg) * 64'(cur_l_reg)) >> 30;
    assign term_full = (64'(sq_reg) * 64'(cur_dv_reg)) >> 30;

    // saturating adds
    assign l_add   = {1'b0, l_rdata[pic_pkg::VAL_W-1:0]} + {2'b00, cur_l_reg[31:1]};
    assign sum_add = {1'b0, sum_reg} + {1'b0, term_reg};

    // final F
    always_comb begin
        f_diff = sum_reg - pic_pkg::Q_ONE;
        f_clip = 1'b0;
        if (sum_reg < pic_pkg::Q_ONE) begin
            f_val = '0;
        end else if (f_diff > pic_pkg::Q_ONE) begin
            f_val  = pic_pkg::Q_ONE[pic_pkg::FV_W-1:0];
            f_clip = 1'b1;
        end else begin
            f_val = f_diff[pic_pkg::FV_W-1:0];
        end
    end

    assign idle     = (state_reg == ST_IDLE);
    assign done     = (state_reg == ST_FIN) && out_free;
    assign res.idx  = idx_reg;
    assign res.f    = f_val;
    assign res.dv   = dv_reg;
    assign res.err  = err_reg;
    assign res.sat  = sat_reg | f_clip;
    assign f_we     = done;
    assign pd_we    = (state_reg == ST_F1);

    // memory addressing
    always_comb begin
        l_we     = 1'b0;
        l_waddr  = k_reg;
        l_wdata  = '0;
        l_raddr  = k_reg;
        pd_raddr = k_reg;
        f_raddr  = pic_pkg::IDX_W'(job.sire_code - pic_pkg::CODE_W'(1));
        case (state_reg)
            ST_CLR: begin
                l_we    = 1'b1;
                l_waddr = clr_reg;
            end
            ST_F0: f_raddr = pic_pkg::IDX_W'(dc_reg - pic_pkg::CODE_W'(1));
            ST_P0R: l_raddr = pic_pkg::IDX_W'(sc_reg - pic_pkg::CODE_W'(1));
            ST_P0W: begin
                l_we    = (sc_reg != '0);
                l_waddr = pic_pkg::IDX_W'(sc_reg - pic_pkg::CODE_W'(1));
                l_wdata = {1'b1, l_add[pic_pkg::VAL_W] ? pic_pkg::SAT32
                                                       : l_add[pic_pkg::VAL_W-1:0]};
            end
            ST_P1R: l_raddr = pic_pkg::IDX_W'(dc_reg - pic_pkg::CODE_W'(1));
            ST_P1W: begin
                l_we    = (dc_reg != '0);
                l_waddr = pic_pkg::IDX_W'(dc_reg - pic_pkg::CODE_W'(1));
                l_wdata = {1'b1, l_add[pic_pkg::VAL_W] ? pic_pkg::SAT32
                                                       : l_add[pic_pkg::VAL_W-1:0]};
            end
            ST_SC: begin
                // listed entry: clear it as it is taken; else read the next one
                l_we     = l_rdata[pic_pkg::VAL_W];
                l_raddr  = k_reg - 1'b1;
                pd_raddr = k_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == pic_pkg::IDX_W'(pic_pkg::MAX_ANIMALS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        idx_reg   <= job.idx;
                        sc_reg    <= job.sire_code;
                        dc_reg    <= job.dam_code;
                        err_reg   <= job.err;
                        state_reg <= ST_F0;
                    end
                end
                ST_F0: begin
                    dv_reg    <= pic_pkg::Q_ONE[pic_pkg::FV_W-1:0]
                                 - ((sc_reg != '0) ? quarter[pic_pkg::FV_W-1:0] : '0);
                    state_reg <= ST_F1;
                end
                ST_F1: begin
                    dv_reg     <= dv_fin;
                    cur_dv_reg <= dv_fin;
                    cur_l_reg  <= pic_pkg::Q_ONE;
                    sum_reg    <= '0;
                    sat_reg    <= 1'b0;
                    k_reg      <= idx_reg;
                    state_reg  <= ST_P0R;
                end
                ST_P0R: begin
                    sq_reg    <= (|sq_full[63:32]) ? pic_pkg::SAT32 : sq_full[31:0];
                    if (|sq_full[63:32]) sat_reg <= 1'b1;
                    state_reg <= ST_P0W;
                end
                ST_P0W: begin
                    term_reg  <= (|term_full[63:32]) ? pic_pkg::SAT32 : term_full[31:0];
                    // term clip or sire weight clip
                    if ((|term_full[63:32]) || ((sc_reg != '0) && l_add[pic_pkg::VAL_W]))
                        sat_reg <= 1'b1;
                    state_reg <= ST_P1R;
                end
                ST_P1R: begin
                    sum_reg   <= sum_add[pic_pkg::VAL_W] ? pic_pkg::SAT32
                                                         : sum_add[pic_pkg::VAL_W-1:0];
                    if (sum_add[pic_pkg::VAL_W]) sat_reg <= 1'b1;
                    state_reg <= ST_P1W;
                end
                ST_P1W: begin
                    if ((dc_reg != '0) && l_add[pic_pkg::VAL_W]) sat_reg <= 1'b1;
                    if (k_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= ST_SR;
                    end
                end
                ST_SR: state_reg <= ST_SC;
                ST_SC: begin
                    if (l_rdata[pic_pkg::VAL_W]) begin
                        cur_l_reg  <= l_rdata[pic_pkg::VAL_W-1:0];
                        sc_reg     <= par_rdata[pic_pkg::PAR_W-1:pic_pkg::CODE_W];
                        dc_reg     <= par_rdata[pic_pkg::CODE_W-1:0];
                        cur_dv_reg <= d_rdata;
                        state_reg  <= ST_P0R;
                    end else if (k_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // path weight store with listed flag
    pic_ram #(.WIDTH(pic_pkg::LW_W), .DEPTH(pic_pkg::MAX_ANIMALS)) u_l_ram (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    // inbreeding table
    pic_ram #(.WIDTH(pic_pkg::FV_W), .DEPTH(pic_pkg::MAX_ANIMALS)) u_f_ram (
        .aclk(aclk), .we(f_we), .waddr(idx_reg), .wdata(f_val),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    // parent codes
    pic_ram #(.WIDTH(pic_pkg::PAR_W), .DEPTH(pic_pkg::MAX_ANIMALS)) u_par_ram (
        .aclk(aclk), .we(pd_we), .waddr(idx_reg), .wdata({sc_reg, dc_reg}),
        .raddr(pd_raddr), .rdata(par_rdata)
    );

    // Mendelian variance table
    pic_ram #(.WIDTH(pic_pkg::FV_W), .DEPTH(pic_pkg::MAX_ANIMALS)) u_d_ram (
        .aclk(aclk), .we(pd_we), .waddr(idx_reg), .wdata(dv_fin),
        .raddr(pd_raddr), .rdata(d_rdata)
    );

endmodule

/* hdl/pedigree_inbreeding_coefficients_top.sv */
// ----------------------------------------------------------------------------
// pedigree_inbreeding_coefficients_top: inbreeding coefficients by ancestor walk
//
// Input channel (s_): one individual per item, in pedigree order, with sire and
// dam indices and known flags. s_new_pedigree restarts numbering at 0; the
// count also wraps to 0 after the last table entry.
// Result channel (m_): one item per input: assigned index, F, d (Q1.30),
// parent_error for a known parent that is not earlier, saturated on clipping.
// The engine takes the parents' F, then scans the path weight store from the
// individual down to index 0, visiting each listed ancestor; this scan sets the
// rate, so the time for individual i grows with i and with its ancestor count.
// One item is in the engine at a time; the next one is taken as soon as the
// result sits in the output register, even if the receiver stalls it.
// A stalled result holds the engine at its last step until the output frees.
// Reset: the path weight store is swept to zero with s_ready low; the individual
// count returns to 0.
// ----------------------------------------------------------------------------
module pedigree_inbreeding_coefficients_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_new_pedigree,
    input  logic [pic_pkg::IDX_W-1:0]   s_sire_index,
    input  logic                        s_sire_known,
    input  logic [pic_pkg::IDX_W-1:0]   s_dam_index,
    input  logic                        s_dam_known,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pic_pkg::IDX_W-1:0]   m_individual_index,
    output logic [pic_pkg::FV_W-1:0]    m_inbreeding,
    output logic [pic_pkg::FV_W-1:0]    m_mendelian_variance,
    output logic                        m_parent_error,
    output logic                        m_saturated
);

    logic [pic_pkg::CNT_W-1:0] cnt_reg;
    logic [pic_pkg::IDX_W-1:0] idx_new;
    logic                      sire_ok, dam_ok;
    logic                      accept, out_free, idle, done;
    pic_pkg::job_t             job;
    pic_pkg::res_t             res;
    pic_pkg::res_t             out_reg;
    logic                      m_valid_reg;

    // index assignment and parent check
    assign idx_new = (s_new_pedigree || cnt_reg == pic_pkg::CNT_W'(pic_pkg::MAX_ANIMALS))
                     ? '0 : cnt_reg[pic_pkg::IDX_W-1:0];
    assign sire_ok = s_sire_known && (s_sire_index < idx_new);
    assign dam_ok  = s_dam_known && (s_dam_index < idx_new);

    assign job.idx       = idx_new;
    assign job.sire_code = sire_ok ? pic_pkg::CODE_W'(s_sire_index) + 1'b1 : '0;
    assign job.dam_code  = dam_ok ? pic_pkg::CODE_W'(s_dam_index) + 1'b1 : '0;
    assign job.err       = (s_sire_known && !sire_ok) || (s_dam_known && !dam_ok);

    assign s_ready  = idle;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= pic_pkg::CNT_W'(idx_new) + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) out_reg <= res;
    end

    assign m_valid              = m_valid_reg;
    assign m_individual_index   = out_reg.idx;
    assign m_inbreeding         = out_reg.f;
    assign m_mendelian_variance = out_reg.dv;
    assign m_parent_error       = out_reg.err;
    assign m_saturated          = out_reg.sat;

    pic_walk u_walk (
        .aclk(aclk), .aresetn(aresetn), .start(accept), .job(job), .idle(idle),
        .out_free(out_free), .done(done), .res(res)
    );

endmodule

/* hdl/pic_checker.sv */
// ----------------------------------------------------------------------------
// pic_checker: port-level checks for the inbreeding coefficient block
// Watches the handshakes and result ranges; bound to the top level.
// ----------------------------------------------------------------------------
module pic_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [pic_pkg::FV_W-1:0]  m_inbreeding,
    input logic [pic_pkg::FV_W-1:0]  m_mendelian_variance
);

    // store sweep after reset keeps the input closed
    a_reset_closed: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // results stay within Q2.30 one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_inbreeding <= pic_pkg::Q_ONE[pic_pkg::FV_W-1:0])
                 && (m_mendelian_variance <= pic_pkg::Q_ONE[pic_pkg::FV_W-1:0]))
        else $error("result above 1.0");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inbreeding))
        else $error("stalled result changed");

endmodule

bind pedigree_inbreeding_coefficients_top pic_checker u_pic_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_inbreeding(m_inbreeding),
    .m_mendelian_variance(m_mendelian_variance)
);
